[sv/wpr_pkg.sv]
// ----------------------------------------------------------------------------
// wpr_pkg: shared types and constants of the wav pcm frame level reader
// Header layout positions, result status codes, controller command and
// datapath status structs, and the header tag lookup.
// ----------------------------------------------------------------------------
package wpr_pkg;

  // header geometry
  localparam int unsigned HEADER_BYTES = 44;
  localparam int unsigned MAX_CHANNELS = 8;

  localparam logic [5:0] POS_HDR_LAST    = 6'(HEADER_BYTES - 1);
  localparam logic [5:0] POS_FMT_LEN     = 6'd19;
  localparam logic [5:0] POS_FMT_TAG     = 6'd21;
  localparam logic [5:0] POS_CHANNELS    = 6'd23;
  localparam logic [5:0] POS_BLOCK_ALIGN = 6'd33;
  localparam logic [5:0] POS_BITS        = 6'd35;

  // supported sample widths
  localparam logic [5:0] BITS_8  = 6'd8;
  localparam logic [5:0] BITS_16 = 6'd16;
  localparam logic [5:0] BITS_32 = 6'd32;

  // result status codes
  localparam logic [1:0] STAT_FRAME        = 2'd0;
  localparam logic [1:0] STAT_HDR_MISMATCH = 2'd1;
  localparam logic [1:0] STAT_UNSUPPORTED  = 2'd2;

  // level divider geometry
  localparam int unsigned QUO_BITS = 8;
  localparam int unsigned DIVIDEND_BITS = 12;
  localparam int unsigned CHAN_BITS = 4;

  // controller to datapath commands
  typedef struct packed {
    logic       restart;
    logic       hdr_byte;
    logic       data_byte;
    logic       div_start;
    logic       load_err;
    logic [1:0] err_code;
    logic       out_load;
  } wpr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic hdr_last;
    logic hdr_fail;
    logic layout_fail;
    logic short_data;
    logic frame_skip;
    logic frame_end;
    logic frame_last;
    logic div_done;
  } wpr_stat_t;

  // expected tag byte at a header position: {is_tag, byte}
  function automatic logic [8:0] tag_at(input logic [5:0] pos);
    logic [8:0] t;
    t = 9'h000;
    case (pos)
      6'd0:  t = {1'b1, 8'h52}; // R
      6'd1:  t = {1'b1, 8'h49}; // I
      6'd2:  t = {1'b1, 8'h46}; // F
      6'd3:  t = {1'b1, 8'h46}; // F
      6'd8:  t = {1'b1, 8'h57}; // W
      6'd9:  t = {1'b1, 8'h41}; // A
      6'd10: t = {1'b1, 8'h56}; // V
      6'd11: t = {1'b1, 8'h45}; // E
      6'd12: t = {1'b1, 8'h66}; // f
      6'd13: t = {1'b1, 8'h6d}; // m
      6'd14: t = {1'b1, 8'h74}; // t
      6'd36: t = {1'b1, 8'h64}; // d
      6'd37: t = {1'b1, 8'h61}; // a
      6'd38: t = {1'b1, 8'h74}; // t
      6'd39: t = {1'b1, 8'h61}; // a
      default: t = 9'h000;
    endcase
    return t;
  endfunction

endpackage

[sv/wpr_in_if.sv]
// ----------------------------------------------------------------------------
// wpr_in_if: byte stream channel
// Valid/ready channel carrying one file byte and the start of file flag.
// ----------------------------------------------------------------------------
interface wpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink (input valid, input data_byte, input start_of_file, output ready);
endinterface

[sv/wpr_out_if.sv]
// ----------------------------------------------------------------------------
// wpr_out_if: frame level result channel
// Valid/ready channel carrying a level, a status code and the last frame flag.
// ----------------------------------------------------------------------------
interface wpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] level;
  logic [1:0] status;
  logic       last_frame;

  modport source (output valid, output level, output status, output last_frame,
                  input ready);
  modport sink (input valid, input level, input status, input last_frame,
                output ready);
endinterface

[sv/wpr_div.sv]
// ----------------------------------------------------------------------------
// wpr_div: iterative level divider
// Restoring division of the scaled frame sum by the channel count, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module wpr_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [wpr_pkg::DIVIDEND_BITS-1:0]  dividend_i,
  input  logic [wpr_pkg::CHAN_BITS-1:0]      divisor_i,
  output logic                               done_o,
  output logic [wpr_pkg::QUO_BITS-1:0]       quotient_o
);

  localparam int unsigned CntBits = $clog2(wpr_pkg::QUO_BITS);

  logic                            busy_q;
  logic [CntBits-1:0]              cnt_q;
  logic [wpr_pkg::CHAN_BITS-1:0]   rem_q;
  logic [wpr_pkg::QUO_BITS-1:0]    num_q;
  logic [wpr_pkg::CHAN_BITS:0]     trial;
  logic                            ge;

  // one trial subtraction a step
  assign trial = {rem_q, num_q[wpr_pkg::QUO_BITS-1]};
  assign ge    = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      num_q  <= '0;
    end else if (start_i) begin
      // the top bits are already below the divisor
      busy_q <= 1'b1;
      cnt_q  <= CntBits'(wpr_pkg::QUO_BITS - 1);
      rem_q  <= dividend_i[wpr_pkg::DIVIDEND_BITS-1:wpr_pkg::QUO_BITS];
      num_q  <= dividend_i[wpr_pkg::QUO_BITS-1:0];
    end else if (busy_q) begin
      rem_q <= ge ? wpr_pkg::CHAN_BITS'(trial - {1'b0, divisor_i})
                  : trial[wpr_pkg::CHAN_BITS-1:0];
      num_q <= {num_q[wpr_pkg::QUO_BITS-2:0], ge};
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = num_q;

endmodule

[sv/wpr_datapath.sv]
// ----------------------------------------------------------------------------
// wpr_datapath: header fields, frame accumulation and result registers
// Parses the header fields, assembles little-endian samples, sums a frame,
// scales it and hands the quotient to the output register.
// ----------------------------------------------------------------------------
module wpr_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wpr_pkg::wpr_cmd_t cmd_i,
  input  logic [7:0]        byte_i,
  output wpr_pkg::wpr_stat_t stat_o,
  output logic [7:0]        level_o,
  output logic [1:0]        status_o,
  output logic              last_frame_o
);

  logic [5:0]  pos_q;
  logic [31:0] scr_q;
  logic        hdr_ok_q, fmt_ok_q;
  logic [3:0]  chan_q;
  logic [5:0]  bits_q;
  logic [15:0] fb_q;
  logic [31:0] left_q;
  logic [15:0] idx_q;
  logic [31:0] asm_q;
  logic [35:0] sum_q;
  logic [1:0]  pend_status_q;
  logic        pend_last_q;
  logic [7:0]  out_level_q;
  logic [1:0]  out_status_q;
  logic        out_last_q;

  logic [5:0]  pos_cur;
  logic        ok_cur, fmt_cur, ok_new, fmt_new;
  logic [31:0] scr_new;
  logic [15:0] half;
  logic [8:0]  tag;
  logic [3:0]  chan_new;
  logic [5:0]  bits_new;
  logic [15:0] fb_new;
  logic [5:0]  used;
  logic [1:0]  kmask, k;
  logic        samp_end, in_use, skip;
  logic [31:0] asm_new;
  logic [35:0] sum_new, sum_fin;
  logic [15:0] idx_inc;
  logic [31:0] left_dec;
  logic [11:0] dividend;
  logic [7:0]  quotient;
  logic        div_done;

  // header field decode
  always_comb begin
    pos_cur  = cmd_i.restart ? 6'd0 : pos_q;
    ok_cur   = cmd_i.restart | hdr_ok_q;
    fmt_cur  = cmd_i.restart | fmt_ok_q;
    scr_new  = {byte_i, scr_q[31:8]};
    half     = scr_new[31:16];
    tag      = wpr_pkg::tag_at(pos_cur);
    ok_new   = ok_cur & ~(tag[8] && (tag[7:0] != byte_i))
                      & ~((pos_cur == wpr_pkg::POS_FMT_LEN) && (scr_new != 32'd16));
    fmt_new  = fmt_cur & ~((pos_cur == wpr_pkg::POS_FMT_TAG) && (half != 16'd1));
    chan_new = chan_q;
    bits_new = bits_q;
    fb_new   = fb_q;
    if (pos_cur == wpr_pkg::POS_CHANNELS) begin
      chan_new = ((half != 16'd0) && (half <= 16'(wpr_pkg::MAX_CHANNELS))) ? half[3:0]
                                                                           : 4'd0;
    end
    if (pos_cur == wpr_pkg::POS_BLOCK_ALIGN) begin
      fb_new = half;
    end
    if (pos_cur == wpr_pkg::POS_BITS) begin
      bits_new = ((half == 16'd8) || (half == 16'd16) || (half == 16'd32)) ? half[5:0]
                                                                           : 6'd0;
    end
  end

  // bytes of samples per frame and byte lane mask
  always_comb begin
    case (bits_q)
      wpr_pkg::BITS_8: begin
        used  = {2'b00, chan_q};
        kmask = 2'b00;
      end
      wpr_pkg::BITS_16: begin
        used  = {1'b0, chan_q, 1'b0};
        kmask = 2'b01;
      end
      wpr_pkg::BITS_32: begin
        used  = {chan_q, 2'b00};
        kmask = 2'b11;
      end
      default: begin
        used  = 6'd0;
        kmask = 2'b00;
      end
    endcase
  end

  // sample assembly and frame sum
  always_comb begin
    skip     = (idx_q == 16'd0) && (left_q < {16'd0, fb_q});
    k        = idx_q[1:0] & kmask;
    samp_end = (k == kmask);
    in_use   = idx_q < {10'd0, used};
    asm_new  = asm_q | ({24'd0, byte_i} << {k, 3'b000});
    sum_new  = sum_q + {4'd0, asm_new};
    idx_inc  = idx_q + 16'd1;
    left_dec = left_q - 32'd1;
    sum_fin  = (in_use && samp_end) ? sum_new : sum_q;
    case (bits_q)
      wpr_pkg::BITS_16: dividend = sum_fin[19:8];
      wpr_pkg::BITS_32: dividend = sum_fin[35:24];
      default:          dividend = sum_fin[11:0];
    endcase
  end

  // status to the controller
  always_comb begin
    stat_o.hdr_last    = pos_cur == wpr_pkg::POS_HDR_LAST;
    stat_o.hdr_fail    = ~ok_new;
    stat_o.layout_fail = ~fmt_new | (chan_q == 4'd0) | (bits_q == 6'd0)
                       | (fb_q < {10'd0, used});
    stat_o.short_data  = scr_new < {16'd0, fb_q};
    stat_o.frame_skip  = skip;
    stat_o.frame_end   = ~skip && (idx_inc == fb_q);
    stat_o.frame_last  = left_dec < {16'd0, fb_q};
    stat_o.div_done    = div_done;
  end

  // parse and accumulate registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= '0;
      scr_q         <= '0;
      hdr_ok_q      <= 1'b1;
      fmt_ok_q      <= 1'b1;
      chan_q        <= '0;
      bits_q        <= '0;
      fb_q          <= '0;
      left_q        <= '0;
      idx_q         <= '0;
      asm_q         <= '0;
      sum_q         <= '0;
      pend_status_q <= wpr_pkg::STAT_FRAME;
      pend_last_q   <= 1'b0;
    end else begin
      if (cmd_i.hdr_byte) begin
        pos_q    <= stat_o.hdr_last ? pos_cur : pos_cur + 6'd1;
        scr_q    <= scr_new;
        hdr_ok_q <= ok_new;
        fmt_ok_q <= fmt_new;
        chan_q   <= chan_new;
        bits_q   <= bits_new;
        fb_q     <= fb_new;
        if (stat_o.hdr_last) begin
          left_q <= scr_new;
          idx_q  <= '0;
          asm_q  <= '0;
          sum_q  <= '0;
        end
      end
      if (cmd_i.data_byte && !skip) begin
        left_q <= left_dec;
        if (stat_o.frame_end) begin
          idx_q         <= '0;
          asm_q         <= '0;
          sum_q         <= '0;
          pend_status_q <= wpr_pkg::STAT_FRAME;
          pend_last_q   <= stat_o.frame_last;
        end else begin
          idx_q <= idx_inc;
          if (in_use) begin
            if (samp_end) begin
              sum_q <= sum_new;
              asm_q <= '0;
            end else begin
              asm_q <= asm_new;
            end
          end
        end
      end
      if (cmd_i.load_err) begin
        pend_status_q <= cmd_i.err_code;
        pend_last_q   <= 1'b0;
      end
    end
  end

  // level divider
  wpr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (chan_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // output payload register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_level_q  <= (pend_status_q == wpr_pkg::STAT_FRAME) ? quotient : 8'd0;
      out_status_q <= pend_status_q;
      out_last_q   <= pend_last_q;
    end
  end

  assign level_o      = out_level_q;
  assign status_o     = out_status_q;
  assign last_frame_o = out_last_q;

endmodule

[sv/wpr_ctrl.sv]
// ----------------------------------------------------------------------------
// wpr_ctrl: parse and result controller
// Tracks the parse phase of the file, issues byte commands to the datapath
// and moves each result through the divider and into the output register.
// ----------------------------------------------------------------------------
module wpr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               start_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  input  wpr_pkg::wpr_stat_t stat_i,
  output wpr_pkg::wpr_cmd_t  cmd_o
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [1:0] RES_FREE = 2'd0;
  localparam logic [1:0] RES_DIV  = 2'd1;
  localparam logic [1:0] RES_HOLD = 2'd2;

  logic [1:0] phase_q, phase_d, phase_cur;
  logic [1:0] res_q, res_d;
  logic       out_valid_q, out_valid_d;
  logic       acc;

  assign in_ready_o = (res_q == RES_FREE);
  assign acc        = in_valid_i & in_ready_o;
  assign phase_cur  = start_i ? PH_HEADER : phase_q;

  // parse phase and result hand-off
  always_comb begin
    cmd_o          = '0;
    cmd_o.err_code = wpr_pkg::STAT_FRAME;
    cmd_o.restart  = acc & start_i;
    phase_d        = phase_q;
    res_d          = res_q;
    out_valid_d    = out_valid_q;
    if (acc) begin
      phase_d = phase_cur;
      unique case (phase_cur)
        PH_HEADER: begin
          cmd_o.hdr_byte = 1'b1;
          if (stat_i.hdr_last) begin
            if (stat_i.hdr_fail) begin
              phase_d        = PH_DONE;
              cmd_o.load_err = 1'b1;
              cmd_o.err_code = wpr_pkg::STAT_HDR_MISMATCH;
            end else if (stat_i.layout_fail) begin
              phase_d        = PH_DONE;
              cmd_o.load_err = 1'b1;
              cmd_o.err_code = wpr_pkg::STAT_UNSUPPORTED;
            end else begin
              phase_d = stat_i.short_data ? PH_DONE : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          cmd_o.data_byte = 1'b1;
          if (stat_i.frame_skip) begin
            phase_d = PH_DONE;
          end else if (stat_i.frame_end) begin
            cmd_o.div_start = 1'b1;
            if (stat_i.frame_last) begin
              phase_d = PH_DONE;
            end
          end
        end
        default: ;
      endcase
    end

    // result hand-off
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (res_q)
      RES_FREE: begin
        if (cmd_o.load_err) begin
          res_d = RES_HOLD;
        end else if (cmd_o.div_start) begin
          res_d = RES_DIV;
        end
      end
      RES_DIV: begin
        if (stat_i.div_done) begin
          res_d = RES_HOLD;
        end
      end
      RES_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          res_d          = RES_FREE;
        end
      end
      default: res_d = RES_FREE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      res_q       <= RES_FREE;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/wav_pcm_frame_level_reader_unit.sv]
// ----------------------------------------------------------------------------
// wav_pcm_frame_level_reader_unit: wav pcm header parser and frame level meter
// Takes a wav file a byte at a time, checks its 44-byte header and reports
// one scaled level per complete frame of 8, 16 or 32 bit samples.
// ----------------------------------------------------------------------------
// The byte that closes a frame starts an eight-step restoring divider (one
// quotient bit a cycle, dividing the scaled sum by the channel count), and
// the input is held off until the level has moved to the output register.
// A header fault or unsupported layout gives one report on the last header
// byte, and bytes are then ignored until the next start of file. The output
// register lets the next bytes come in while a level is still waiting to be
// taken.
module wav_pcm_frame_level_reader_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  wpr_in_if.sink          in_i,
  wpr_out_if.source       out_o
);

  wpr_pkg::wpr_cmd_t  cmd;
  wpr_pkg::wpr_stat_t stat;

  // parse and result controller
  wpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .start_i     (in_i.start_of_file),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // header, sample and level datapath
  wpr_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .byte_i       (in_i.data_byte),
    .stat_o       (stat),
    .level_o      (out_o.level),
    .status_o     (out_o.status),
    .last_frame_o (out_o.last_frame)
  );

  // no request is taken while a level is being divided
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> !in_i.ready)
    else $error("input accepted during level division");

  // a finished division waits for the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.div_done |=> !in_i.ready)
    else $error("input accepted before level hand-off");

  // error reports carry no level and no last frame mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status != wpr_pkg::STAT_FRAME))
      |-> (out_o.level == 8'd0) && !out_o.last_frame)
    else $error("error report with level or last frame set");

  // a byte is either a header byte or a data byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.hdr_byte && cmd.data_byte))
    else $error("byte taken as header and data");

endmodule

[dv/tb_wav_pcm_frame_level_reader_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wav_pcm_frame_level_reader_unit: byte stream test of the wav level reader
// Feeds whole wav files, broken headers, unsupported layouts, restarts and
// stray bytes into the byte channel with random gaps, follows every accepted
// byte with a cycle-free predictor of the parser, and checks each level or
// error report against the oldest one the predictor produced.
// ----------------------------------------------------------------------------
module tb_wav_pcm_frame_level_reader_unit;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 30;

  typedef enum logic [1:0] {PHASE_IDLE, PHASE_HEADER, PHASE_DATA, PHASE_DONE} reader_phase_e;
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

  typedef struct packed {
    logic [7:0] value;
    logic       starts_file;
  } file_byte_t;

  typedef struct packed {
    logic [7:0] level;
    logic [1:0] status;
    logic       last_frame;
  } level_report_t;

  typedef struct {
    logic [31:0] riff_size;
    logic [31:0] fmt_len;
    logic [31:0] rate;
    logic [31:0] byte_rate;
    logic [31:0] data_len;
    logic [15:0] fmt_tag;
    logic [15:0] chans;
    logic [15:0] frame_len;
    logic [15:0] bits;
    logic [7:0]  fmt_pad;
    int          flip_pos;
  } wav_header_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  wpr_in_if  in_if ();
  wpr_out_if out_if ();

  wav_pcm_frame_level_reader_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  file_byte_t    pending_bytes[$];
  level_report_t expected_levels[$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            stream_bytes = 0;
  bit            byte_taken = 1'b0;
  bit            result_taken = 1'b0;
  bit            src_calm = 1'b0;
  bit            snk_calm = 1'b0;

  // parser state as the predictor follows it
  reader_phase_e rd_phase;
  logic [5:0]    rd_pos;
  logic [31:0]   rd_scratch;
  bit            rd_hdr_ok;
  bit            rd_fmt_ok;
  logic [3:0]    rd_chans;
  logic [5:0]    rd_bits;
  logic [15:0]   rd_frame_len;
  logic [31:0]   rd_left;
  logic [15:0]   rd_idx;
  logic [31:0]   rd_sample;
  logic [35:0]   rd_sum;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // wait before the next request, with calm stretches of no waiting at all
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 9));
  endfunction

  task automatic clear_reader_state();
    rd_phase     = PHASE_IDLE;
    rd_pos       = '0;
    rd_scratch   = '0;
    rd_hdr_ok    = 1'b1;
    rd_fmt_ok    = 1'b1;
    rd_chans     = '0;
    rd_bits      = '0;
    rd_frame_len = '0;
    rd_left      = '0;
    rd_idx       = '0;
    rd_sample    = '0;
    rd_sum       = '0;
  endtask

  // expected tag character at a header position
  function automatic bit header_tag(input logic [5:0] pos, output logic [7:0] ch);
    ch = 8'h00;
    case (pos)
      6'd0, 6'd1, 6'd2, 6'd3: ch = (pos == 6'd0) ? "R" : (pos == 6'd1) ? "I" : "F";
      6'd8:  ch = "W";
      6'd9:  ch = "A";
      6'd10: ch = "V";
      6'd11: ch = "E";
      6'd12: ch = "f";
      6'd13: ch = "m";
      6'd14: ch = "t";
      6'd36: ch = "d";
      6'd37: ch = "a";
      6'd38: ch = "t";
      6'd39: ch = "a";
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic follow_header_byte(input logic [7:0] b);
    logic [7:0]    tag;
    logic [15:0]   half;
    level_report_t rep;
    if (header_tag(rd_pos, tag) && tag != b) rd_hdr_ok = 1'b0;
    rd_scratch = {b, rd_scratch[31:8]};
    half = rd_scratch[31:16];
    case (rd_pos)
      wpr_pkg::POS_FMT_LEN:     if (rd_scratch != 32'd16) rd_hdr_ok = 1'b0;
      wpr_pkg::POS_FMT_TAG:     if (half != 16'd1) rd_fmt_ok = 1'b0;
      wpr_pkg::POS_CHANNELS:
        rd_chans = (half >= 16'd1 && half <= 16'(wpr_pkg::MAX_CHANNELS)) ? half[3:0] : 4'd0;
      wpr_pkg::POS_BLOCK_ALIGN: rd_frame_len = half;
      wpr_pkg::POS_BITS:
        rd_bits = (half == {10'd0, wpr_pkg::BITS_8} || half == {10'd0, wpr_pkg::BITS_16} ||
                   half == {10'd0, wpr_pkg::BITS_32}) ? half[5:0] : 6'd0;
      default: ;
    endcase
    if (rd_pos != wpr_pkg::POS_HDR_LAST) begin
      rd_pos = rd_pos + 6'd1;
      return;
    end
    // last header byte: latch the data length and judge the header
    rd_left   = rd_scratch;
    rd_idx    = '0;
    rd_sample = '0;
    rd_sum    = '0;
    rep.level      = 8'd0;
    rep.last_frame = 1'b0;
    if (!rd_hdr_ok) begin
      rep.status = wpr_pkg::STAT_HDR_MISMATCH;
      expected_levels.push_back(rep);
      rd_phase = PHASE_DONE;
    end else if (!rd_fmt_ok || rd_chans == 4'd0 || rd_bits == 6'd0 ||
                 int'(rd_frame_len) < int'(rd_chans) * int'(rd_bits >> 3)) begin
      rep.status = wpr_pkg::STAT_UNSUPPORTED;
      expected_levels.push_back(rep);
      rd_phase = PHASE_DONE;
    end else begin
      rd_phase = (rd_left < 32'(rd_frame_len)) ? PHASE_DONE : PHASE_DATA;
    end
  endtask

  task automatic follow_data_byte(input logic [7:0] b);
    int            bps;
    int            used;
    int            k;
    logic [63:0]   scaled;
    logic [63:0]   divisor;
    logic [63:0]   quot;
    level_report_t rep;
    bps  = int'(rd_bits >> 3);
    used = int'(rd_chans) * bps;
    if (rd_idx == 16'd0 && rd_left < 32'(rd_frame_len)) begin
      rd_phase = PHASE_DONE;
      return;
    end
    // assemble little-endian samples, skip padding past the channels
    if (int'(rd_idx) < used) begin
      k = int'(rd_idx) % bps;
      rd_sample = rd_sample | (32'(b) << (8 * k));
      if (k == bps - 1) begin
        rd_sum    = rd_sum + 36'(rd_sample);
        rd_sample = '0;
      end
    end
    rd_idx  = rd_idx + 16'd1;
    rd_left = rd_left - 32'd1;
    if (rd_idx < rd_frame_len) return;
    // frame complete: scaled mean of the channel samples
    scaled  = {20'd0, rd_sum, 8'd0};
    divisor = 64'(rd_chans) << rd_bits;
    quot    = scaled / divisor;
    rep.level      = (quot > 64'd255) ? 8'hFF : quot[7:0];
    rep.status     = wpr_pkg::STAT_FRAME;
    rep.last_frame = (rd_left < 32'(rd_frame_len));
    expected_levels.push_back(rep);
    rd_idx    = '0;
    rd_sample = '0;
    rd_sum    = '0;
    if (rep.last_frame) rd_phase = PHASE_DONE;
  endtask

  task automatic follow_wav_byte(input logic [7:0] b, input logic starts_file);
    if (starts_file) begin
      clear_reader_state();
      rd_phase = PHASE_HEADER;
    end
    if (rd_phase == PHASE_HEADER) follow_header_byte(b);
    else if (rd_phase == PHASE_DATA) follow_data_byte(b);
  endtask

  // stimulus building
  task automatic queue_byte(input logic [7:0] b, input logic starts_file, input bit counted);
    file_byte_t fb;
    fb.value       = b;
    fb.starts_file = starts_file;
    pending_bytes.push_back(fb);
    if (counted) stream_bytes++;
  endtask

  function automatic wav_header_t clean_header(input int chans, input int bits, input int pad,
                                               input logic [31:0] data_len);
    wav_header_t h;
    h.riff_size = data_len + 32'd36;
    h.fmt_len   = 32'd16;
    h.rate      = $urandom;
    h.byte_rate = $urandom;
    h.data_len  = data_len;
    h.fmt_tag   = 16'd1;
    h.chans     = 16'(chans);
    h.bits      = 16'(bits);
    h.frame_len = 16'(chans * bits / 8 + pad);
    h.fmt_pad   = " ";
    h.flip_pos  = -1;
    return h;
  endfunction

  task automatic queue_header(input wav_header_t h, input int upto);
    logic [7:0] hb [0:43];
    hb[0] = "R"; hb[1] = "I"; hb[2] = "F"; hb[3] = "F";
    hb[8] = "W"; hb[9] = "A"; hb[10] = "V"; hb[11] = "E";
    hb[12] = "f"; hb[13] = "m"; hb[14] = "t"; hb[15] = h.fmt_pad;
    hb[36] = "d"; hb[37] = "a"; hb[38] = "t"; hb[39] = "a";
    for (int i = 0; i < 4; i++) begin
      hb[4 + i]  = h.riff_size[8*i +: 8];
      hb[16 + i] = h.fmt_len[8*i +: 8];
      hb[24 + i] = h.rate[8*i +: 8];
      hb[28 + i] = h.byte_rate[8*i +: 8];
      hb[40 + i] = h.data_len[8*i +: 8];
    end
    for (int i = 0; i < 2; i++) begin
      hb[20 + i] = h.fmt_tag[8*i +: 8];
      hb[22 + i] = h.chans[8*i +: 8];
      hb[32 + i] = h.frame_len[8*i +: 8];
      hb[34 + i] = h.bits[8*i +: 8];
    end
    if (h.flip_pos >= 0) hb[h.flip_pos] = hb[h.flip_pos] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < upto; i++) queue_byte(hb[i], i == 0, 1'b1);
  endtask

  task automatic queue_samples(input int count, input fill_e fill);
    for (int i = 0; i < count; i++) begin
      case (fill)
        FILL_ZERO: queue_byte(8'h00, 1'b0, 1'b1);
        FILL_ONES: queue_byte(8'hFF, 1'b0, 1'b1);
        default:   queue_byte(8'($urandom), 1'b0, 1'b1);
      endcase
    end
  endtask

  function automatic int tag_position(input int n);
    return (n < 4) ? n : (n < 11) ? n + 4 : n + 25;
  endfunction

  task automatic queue_good_file();
    wav_header_t h;
    int          chans;
    int          bits;
    int          pick;
    int          flen;
    int          frames;
    int          dlen;
    int          sent;
    fill_e       fill;
    chans = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 2);
    pick  = $urandom_range(0, 9);
    bits  = (pick < 4) ? 8 : (pick < 8) ? 16 : 32;
    h     = clean_header(chans, bits, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, 0);
    flen  = int'(h.frame_len);
    frames = (flen > 8) ? $urandom_range(0, 3) : $urandom_range(0, 8);
    dlen  = frames * flen + (($urandom_range(0, 1) == 1) ? $urandom_range(0, flen - 1) : 0);
    h.data_len  = 32'(dlen);
    h.riff_size = 32'(dlen + 36);
    h.fmt_pad   = ($urandom_range(0, 4) == 0) ? 8'($urandom) : " ";
    pick = $urandom_range(0, 9);
    fill = (pick == 0) ? FILL_ONES : (pick == 1) ? FILL_ZERO : FILL_RANDOM;
    // mostly the whole data chunk, at times cut short or with trailing bytes
    pick = $urandom_range(0, 9);
    sent = (pick == 0) ? $urandom_range(0, dlen) :
           (pick < 3) ? dlen + $urandom_range(1, 4) : dlen;
    queue_header(h, 44);
    queue_samples(sent, fill);
  endtask

  task automatic queue_broken_file();
    wav_header_t h;
    h = clean_header($urandom_range(1, 4), 8, 0, $urandom_range(0, 8));
    if ($urandom_range(0, 3) == 0) begin
      h.fmt_len = $urandom;
      if (h.fmt_len == 32'd16) h.fmt_len = 32'd17;
    end else begin
      h.flip_pos = tag_position($urandom_range(0, 14));
    end
    queue_header(h, 44);
    queue_samples($urandom_range(0, 6), FILL_RANDOM);
  endtask

  task automatic queue_odd_layout_file();
    wav_header_t h;
    int          pick;
    h = clean_header(1, 8, 0, $urandom_range(0, 80));
    h.chans = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 10)) : 16'($urandom);
    pick = $urandom_range(0, 7);
    case (pick)
      0: h.bits = 16'd0;
      1: h.bits = 16'd8;
      2: h.bits = 16'd16;
      3: h.bits = 16'd24;
      4: h.bits = 16'd32;
      5: h.bits = 16'd64;
      default: h.bits = 16'($urandom);
    endcase
    h.frame_len = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 40)) : 16'($urandom);
    if ($urandom_range(0, 3) == 0) h.fmt_tag = 16'($urandom);
    queue_header(h, 44);
    queue_samples($urandom_range(0, 80), FILL_RANDOM);
  endtask

  task automatic build_stimulus();
    wav_header_t h;
    int          pick;
    // stray bytes before any start of file
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h5A, 1'b0, 1'b0);
    // mono 8 bit at full scale, two frames
    queue_header(clean_header(1, 8, 0, 2), 44);
    queue_samples(2, FILL_ONES);
    // eight channels of 32 bit at full scale, then silence
    queue_header(clean_header(8, 32, 0, 64), 44);
    queue_samples(32, FILL_ONES);
    queue_samples(32, FILL_ZERO);
    // stereo 16 bit with padded frames, partial frame left over, trailing bytes
    queue_header(clean_header(2, 16, 3, 25), 44);
    queue_samples(30, FILL_RANDOM);
    // odd byte in the fmt tag is not checked
    h = clean_header(3, 8, 0, 6);
    h.fmt_pad = 8'($urandom);
    queue_header(h, 44);
    queue_samples(6, FILL_RANDOM);
    // tag faults at the first and last tag bytes
    h = clean_header(1, 8, 0, 4);
    h.flip_pos = 0;
    queue_header(h, 44);
    queue_samples(4, FILL_RANDOM);
    h.flip_pos = 39;
    queue_header(h, 44);
    // format length not 16
    h = clean_header(1, 8, 0, 4);
    h.fmt_len = 32'd18;
    queue_header(h, 44);
    // tag fault together with a bad format tag: mismatch wins
    h = clean_header(1, 8, 0, 4);
    h.flip_pos = 8;
    h.fmt_tag  = 16'd3;
    queue_header(h, 44);
    // unsupported layouts
    h = clean_header(1, 8, 0, 4);
    h.fmt_tag = 16'd3;
    queue_header(h, 44);
    queue_samples(2, FILL_RANDOM);
    h = clean_header(1, 8, 0, 4);
    h.chans = 16'd0;
    queue_header(h, 44);
    h.chans = 16'd9;
    queue_header(h, 44);
    h.chans = 16'hFFFF;
    queue_header(h, 44);
    h = clean_header(1, 8, 0, 4);
    h.bits = 16'd24;
    queue_header(h, 44);
    h.bits = 16'd0;
    queue_header(h, 44);
    h = clean_header(2, 16, 0, 8);
    h.frame_len = 16'd3;
    queue_header(h, 44);
    // empty data chunk, bytes after it are ignored
    queue_header(clean_header(1, 8, 0, 0), 44);
    queue_samples(3, FILL_RANDOM);
    // huge frame that the data chunk cannot fill
    h = clean_header(8, 32, 0, 10);
    h.frame_len = 16'hFFFF;
    queue_header(h, 44);
    queue_samples(10, FILL_RANDOM);
    // restart in the middle of a huge data chunk
    queue_header(clean_header(1, 16, 0, 32'hFFFF_FFFF), 44);
    queue_samples(9, FILL_RANDOM);
    // restart in the middle of the header
    queue_header(clean_header(2, 8, 0, 4), 20);
    queue_header(clean_header(4, 8, 1, 10), 44);
    queue_samples(10, FILL_RANDOM);

    // random files, mostly well formed
    while (stream_bytes < 600) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) queue_good_file();
      else if (pick < 82) queue_broken_file();
      else if (pick < 90) queue_odd_layout_file();
      else if (pick < 95) queue_header(clean_header($urandom_range(1, 8), 16, 0, 8),
                                       $urandom_range(1, 43));
      else for (int i = $urandom_range(1, 5); i > 0; i--) queue_byte(8'($urandom), 1'b0, 1'b0);
    end
  endtask

  // byte request driver
  int gap_left = 0;
  always @(negedge clk_i) begin : feed_bytes
    file_byte_t nxt;
    if (!rst_ni) begin
      in_if.valid         <= 1'b0;
      in_if.data_byte     <= 8'h00;
      in_if.start_of_file <= 1'b0;
    end else if (!in_if.valid || byte_taken) begin
      if (gap_left > 0) begin
        in_if.valid <= 1'b0;
        gap_left--;
      end else if (pending_bytes.size() > 0) begin
        nxt = pending_bytes.pop_front();
        in_if.valid         <= 1'b1;
        in_if.data_byte     <= nxt.value;
        in_if.start_of_file <= nxt.starts_file;
        gap_left = draw_wait(src_calm);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result ready with random stalls
  int hold_left = 0;
  always @(negedge clk_i) begin : take_levels
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (result_taken) hold_left = draw_wait(snk_calm);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // monitor: follow accepted bytes, check accepted results
  always @(posedge clk_i) begin : watch
    level_report_t want;
    byte_taken   = 1'b0;
    result_taken = 1'b0;
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("tb_wav_pcm_frame_level_reader_unit: FAIL");
        $finish;
      end else begin
        if (in_if.valid && in_if.ready) begin
          byte_taken = 1'b1;
          follow_wav_byte(in_if.data_byte, in_if.start_of_file);
        end
        if (out_if.valid && out_if.ready) begin
          result_taken = 1'b1;
          if (expected_levels.size() == 0) begin
            report_mismatch($sformatf("unexpected result level %0d status %0d last %0b",
                                      out_if.level, out_if.status, out_if.last_frame));
          end else begin
            want = expected_levels.pop_front();
            if (out_if.level !== want.level)
              report_mismatch($sformatf("level %0d, expected %0d", out_if.level, want.level));
            if (out_if.status !== want.status)
              report_mismatch($sformatf("status %0d, expected %0d", out_if.status, want.status));
            if (out_if.last_frame !== want.last_frame)
              report_mismatch($sformatf("last frame %0b, expected %0b",
                                        out_if.last_frame, want.last_frame));
          end
        end
      end
    end
  end

  // reset, stimulus and end of run
  initial begin
    clear_reader_state();
    build_stimulus();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (pending_bytes.size() != 0 || in_if.valid) @(posedge clk_i);
    while (expected_levels.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_wav_pcm_frame_level_reader_unit: PASS");
    end else begin
      $display("tb_wav_pcm_frame_level_reader_unit: FAIL");
    end
    $finish;
  end

endmodule
